### rtl/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/pfa_pkg.sv
`default_nettype none
package pfa_pkg;

   // Managed pages and the longest run one allocate word may ask for
   localparam int PAGES   = 1024;
   localparam int MAX_RUN = 64;

   // Field widths
   localparam int FRAME_W = 20;
   localparam int RSV_W   = 11;
   localparam int COUNT_W = 7;

   // Bitmap organization: 32 page bits per memory row
   localparam int WORD_W  = 32;
   localparam int WORDS   = PAGES / WORD_W;
   localparam int IDX_W   = $clog2(PAGES);
   localparam int BIT_W   = $clog2(WORD_W);
   localparam int WADDR_W = $clog2(WORDS);
   localparam int CMP_W   = (IDX_W > RSV_W) ? IDX_W : RSV_W;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_BAD_ADDR = 2'd2
   } status_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic {
      CSR_BASE_PAGE      = 1'b0,
      CSR_RESERVED_PAGES = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_FREE_RD,
      S_FREE_WR,
      S_LOAD,
      S_WAIT,
      S_PICK
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       latch;
      logic       set_free_addr;
      logic       rd_issue;
      logic       load_work;
      logic       take;
      logic       wr_back;
      logic       wr_free;
      logic       word_next;
      logic       scan_reset;
      logic       emit_page;
      logic       emit_single;
      status_type emit_status;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_free;
      logic free_bad;
      logic count_zero;
      logic count_over;
      logic free_any;
      logic run_done;
      logic last_word;
   } dp_status_type;

endpackage
`default_nettype wire

### rtl/pfa_ctrl.sv
`default_nettype none
module pfa_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  pfa_pkg::dp_status_type st,
   output pfa_pkg::ctrl_cmd_type  cmd
);
   import pfa_pkg::*;

   state_type state_ff, state_in;
   logic      commit_ff, commit_in;

   // State and pass registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         commit_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         commit_ff <= commit_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in        = state_ff;
      commit_in       = commit_ff;
      cmd             = '0;
      cmd.emit_status = ST_OK;
      busy            = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            if (st.is_free) begin
               if (st.free_bad) begin
                  cmd.emit_single = 1'b1;
                  cmd.emit_status = ST_BAD_ADDR;
                  state_in        = S_IDLE;
               end else begin
                  cmd.set_free_addr = 1'b1;
                  state_in          = S_FREE_RD;
               end
            end else begin
               priority if (st.count_zero) begin
                  cmd.emit_single = 1'b1;
                  cmd.emit_status = ST_OK;
                  state_in        = S_IDLE;
               end else if (st.count_over) begin
                  cmd.emit_single = 1'b1;
                  cmd.emit_status = ST_NO_SPACE;
                  state_in        = S_IDLE;
               end else begin
                  cmd.scan_reset = 1'b1;
                  commit_in      = 1'b0;
                  state_in       = S_LOAD;
               end
            end
         end
         S_FREE_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_FREE_WR;
         end
         S_FREE_WR: begin
            cmd.wr_free     = 1'b1;
            cmd.emit_single = 1'b1;
            cmd.emit_status = ST_OK;
            state_in        = S_IDLE;
         end
         S_LOAD: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_WAIT;
         end
         S_WAIT: begin
            cmd.load_work = 1'b1;
            state_in      = S_PICK;
         end
         S_PICK: begin
            if (st.free_any) begin
               // Take the lowest free page of the row
               cmd.take      = 1'b1;
               cmd.emit_page = commit_ff;
               if (st.run_done) begin
                  if (commit_ff) begin
                     cmd.wr_back = 1'b1;
                     state_in    = S_IDLE;
                  end else begin
                     // Enough pages seen: restart from row zero and commit
                     cmd.scan_reset = 1'b1;
                     commit_in      = 1'b1;
                     state_in       = S_LOAD;
                  end
               end
            end else begin
               cmd.wr_back = commit_ff;
               if (st.last_word) begin
                  cmd.emit_single = 1'b1;
                  cmd.emit_status = ST_NO_SPACE;
                  state_in        = S_IDLE;
               end else begin
                  cmd.word_next = 1'b1;
                  state_in      = S_LOAD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### rtl/pfa_dpath.sv
`default_nettype none
module pfa_dpath (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_command,
   input  wire [pfa_pkg::COUNT_W-1:0]   req_page_count,
   input  wire [pfa_pkg::FRAME_W-1:0]   req_frame_in,
   input  wire                          csr_we,
   input  wire                          csr_index,
   input  wire [pfa_pkg::FRAME_W-1:0]   csr_data,
   input  pfa_pkg::ctrl_cmd_type        cmd,
   output pfa_pkg::dp_status_type       st,
   output logic                         rsp_strobe,
   output logic [pfa_pkg::FRAME_W-1:0]  rsp_frame_out,
   output logic                         rsp_page_valid,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_last
);
   import pfa_pkg::*;

   // Page index of a bit within a row
   function automatic logic [IDX_W-1:0] page_index(input logic [WADDR_W-1:0] row,
                                                   input logic [BIT_W-1:0] bitpos);
      page_index = (IDX_W'(row) << BIT_W) | IDX_W'(bitpos);
   endfunction

   // Configuration
   logic [FRAME_W-1:0]   base_ff;
   logic [RSV_W-1:0]     rsv_ff;

   // Latched request word
   logic                 cmd_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [FRAME_W-1:0]   frame_ff;

   // Scan state
   logic [WADDR_W-1:0]   word_addr_ff;
   logic [BIT_W-1:0]     bit_ff;
   logic [WORD_W-1:0]    work_ff;
   logic [COUNT_W-1:0]   found_ff;

   // Bitmap memory with per-row valid flags; an unwritten row reads as all free
   logic [WORD_W-1:0]    map_mem [WORDS];
   logic [WORDS-1:0]     word_valid_ff;
   logic [WORD_W-1:0]    rd_data_ff;
   logic                 rd_valid_ff;

   // Result registers
   logic                 rsp_strobe_ff;
   logic [FRAME_W-1:0]   rsp_frame_ff;
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic                 rsp_last_ff;

   logic [WORD_W-1:0]    eff_word;
   logic [WORD_W-1:0]    rsv_mask;
   logic [WORD_W-1:0]    free_mask;
   logic [BIT_W-1:0]     pick_bit;
   logic [WORD_W-1:0]    pick_mask;
   logic [FRAME_W-1:0]   free_idx;
   logic                 wr_en;
   logic [WORD_W-1:0]    wr_data;
   logic [COUNT_W-1:0]   found_inc;

   assign eff_word = rd_valid_ff ? rd_data_ff : '0;

   // Reserved low pages look allocated
   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         rsv_mask[j] = CMP_W'(page_index(word_addr_ff, BIT_W'(j))) < CMP_W'(rsv_ff);
      end
   end

   assign free_mask = ~work_ff & ~rsv_mask;

   // Lowest free bit of the working row
   always_comb begin
      pick_bit = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         if (free_mask[j]) begin
            pick_bit = BIT_W'(j);
         end
      end
   end

   assign pick_mask = WORD_W'(1) << pick_bit;
   assign found_inc = found_ff + COUNT_W'(1);
   assign free_idx  = frame_ff - base_ff;

   // Status to the controller
   assign st.is_free    = (cmd_ff == CMD_FREE);
   assign st.free_bad   = (frame_ff < base_ff)
                        || ({1'b0, free_idx} >= (FRAME_W + 1)'(PAGES))
                        || (free_idx < FRAME_W'(rsv_ff));
   assign st.count_zero = (count_ff == '0);
   assign st.count_over = (count_ff > COUNT_W'(MAX_RUN));
   assign st.free_any   = |free_mask;
   assign st.run_done   = (found_inc == count_ff);
   assign st.last_word  = (word_addr_ff == WADDR_W'(WORDS - 1));

   // Row write: clear one bit for a free, or write back the working row
   assign wr_en   = cmd.wr_back | cmd.wr_free;
   assign wr_data = cmd.wr_free ? (eff_word & ~(WORD_W'(1) << bit_ff))
                                : (work_ff | (cmd.take ? pick_mask : '0));

   // Memory array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[word_addr_ff] <= wr_data;
      end
      if (cmd.rd_issue) begin
         rd_data_ff  <= map_mem[word_addr_ff];
         rd_valid_ff <= word_valid_ff[word_addr_ff];
      end
   end

   // Control registers: configuration, row valid flags, result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         rsv_ff        <= '0;
         word_valid_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_BASE_PAGE:      base_ff <= csr_data;
               CSR_RESERVED_PAGES: rsv_ff  <= csr_data[RSV_W-1:0];
               default:            base_ff <= base_ff;
            endcase
         end
         if (wr_en) begin
            word_valid_ff[word_addr_ff] <= 1'b1;
         end
         rsp_strobe_ff <= cmd.emit_page | cmd.emit_single;
      end
   end

   // Request latch and scan registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff   <= req_command;
         count_ff <= req_page_count;
         frame_ff <= req_frame_in;
      end
      priority if (cmd.scan_reset) begin
         word_addr_ff <= '0;
      end else if (cmd.word_next) begin
         word_addr_ff <= word_addr_ff + WADDR_W'(1);
      end else if (cmd.set_free_addr) begin
         word_addr_ff <= free_idx[IDX_W-1:BIT_W];
      end else begin
         word_addr_ff <= word_addr_ff;
      end
      if (cmd.set_free_addr) begin
         bit_ff <= free_idx[BIT_W-1:0];
      end
      priority if (cmd.scan_reset) begin
         found_ff <= '0;
      end else if (cmd.take) begin
         found_ff <= found_inc;
      end else begin
         found_ff <= found_ff;
      end
      priority if (cmd.load_work) begin
         work_ff <= eff_word;
      end else if (cmd.take) begin
         work_ff <= work_ff | pick_mask;
      end else begin
         work_ff <= work_ff;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      priority if (cmd.emit_page) begin
         rsp_frame_ff  <= base_ff + FRAME_W'(page_index(word_addr_ff, pick_bit));
         rsp_valid_ff  <= 1'b1;
         rsp_status_ff <= ST_OK;
         rsp_last_ff   <= st.run_done;
      end else if (cmd.emit_single) begin
         rsp_frame_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= cmd.emit_status;
         rsp_last_ff   <= 1'b1;
      end else begin
         rsp_frame_ff  <= rsp_frame_ff;
         rsp_valid_ff  <= rsp_valid_ff;
         rsp_status_ff <= rsp_status_ff;
         rsp_last_ff   <= rsp_last_ff;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_frame_out  = rsp_frame_ff;
   assign rsp_page_valid = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
`default_nettype wire

### rtl/page_frame_allocator.sv
// Good free: decode, read the row, clear its bit and report. Bad free, zero or oversized
// allocate: reported from decode. Allocate: decode, a counting scan, then a commit scan
// from row zero (skipped when space runs short); a 32-page row is read, loaded, then picked
// for its free pages; results appear in the cycle after their pick, one per cycle in a row.
// One word at a time: busy drops as the last result is registered. Reset: synchronous;
// per-row valid flags free the whole map at once. The receiver cannot stall results.
`default_nettype none
module page_frame_allocator (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire                          req_command,
   input  wire [pfa_pkg::COUNT_W-1:0]   req_page_count,
   input  wire [pfa_pkg::FRAME_W-1:0]   req_frame_in,
   input  wire                          req_batch_end,
   output logic                         rsp_strobe,
   output logic [pfa_pkg::FRAME_W-1:0]  rsp_frame_out,
   output logic                         rsp_page_valid,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_last,
   input  wire                          csr_we,
   input  wire                          csr_index,
   input  wire [pfa_pkg::FRAME_W-1:0]   csr_data
);
   import pfa_pkg::*;

   // req_batch_end is informational only and does not alter the map or results

   ctrl_cmd_type  cmd;
   dp_status_type st;

   pfa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   pfa_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_page_count (req_page_count),
      .req_frame_in   (req_frame_in),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .st             (st),
      .rsp_strobe     (rsp_strobe),
      .rsp_frame_out  (rsp_frame_out),
      .rsp_page_valid (rsp_page_valid),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire

### rtl/pfa_checker.sv
`default_nettype none
`include "assert_macros.svh"
module pfa_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          start,
   input wire                          busy,
   input wire                          rsp_strobe,
   input wire [pfa_pkg::FRAME_W-1:0]   rsp_frame_out,
   input wire                          rsp_page_valid,
   input wire [1:0]                    rsp_status,
   input wire                          rsp_last
);
   import pfa_pkg::*;

   // A result without a page closes its word
   `ASSERT_RST(a_empty_is_last, clock, reset, rsp_strobe && !rsp_page_valid |-> rsp_last, "result without page is not last")

   // A granted page always reports ok
   `ASSERT_RST(a_page_ok, clock, reset, rsp_strobe && rsp_page_valid |-> rsp_status == ST_OK, "granted page with non-ok status")

   // No frame number travels without a page
   `ASSERT_RST(a_empty_frame, clock, reset, rsp_strobe && !rsp_page_valid |-> rsp_frame_out == '0, "frame set without page")

   // An accepted word keeps the block busy in the next cycle
   `ASSERT_RST(a_accept_busy, clock, reset, start && !busy |=> busy, "accepted word did not raise busy")

   // Reset silences the result strobe
   `ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_strobe, "result strobe right after reset")

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (.*);
`default_nettype wire
